@@ design/stun_traceroute_hop_controller_unit_macros.svh @@
// Assertion macros shared by the traceroute hop controller RTL.
`ifndef STUN_TRACEROUTE_HOP_CONTROLLER_UNIT_MACROS_SVH
`define STUN_TRACEROUTE_HOP_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STHC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sthc check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STHC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sthc check failed");

`endif

@@ design/sthc_pkg.sv @@
// Types, codes and result builders for the traceroute hop controller.
`default_nettype none

package sthc_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W   = 192;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 200;
    localparam int OUT_TUSER_W  = 1;

    // Configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic REG_MAX_TRACES = 1'b0;
    localparam logic REG_HOP_LIMIT  = 1'b1;
    localparam logic [7:0] MAX_TRACES_RST = 8'd1;
    localparam logic [6:0] HOP_LIMIT_RST  = 7'd40;

    // ICMP message types
    localparam logic [7:0] ICMP4_UNREACH  = 8'd3;
    localparam logic [7:0] ICMP6_UNREACH  = 8'd1;
    localparam logic [7:0] ICMP4_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP6_EXCEEDED = 8'd3;

    localparam logic [7:0] PATH_OPEN = 8'd255;

    localparam logic KIND_PROBE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_BIND   = 2'd1,
        REQ_ICMP   = 2'd2,
        REQ_SILENT = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_req        req_type;
        logic [7:0]  ttl;
        logic [7:0]  icmp_type;
        logic        is_ipv6;
        logic        src_is_remote;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [31:0] round_trip;
        logic [7:0]  resend_count;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  probe_ttl;
        logic [7:0]  hop;
        logic        node_valid;
        logic [63:0] node_addr_hi;
        logic [63:0] node_addr_lo;
        logic [31:0] report_rtt;
        logic [7:0]  report_resends;
        logic [7:0]  trace_number;
        logic        trace_end;
        logic        all_done;
        logic        last;
    } t_res;

    // Control from the sequencer to the result queue
    typedef struct packed {
        logic       push;
        logic [1:0] nres;
    } t_q_push;

    function automatic t_res mk_probe(input logic [7:0] ttl);
        t_res r;
        r           = '0;
        r.kind      = KIND_PROBE;
        r.probe_ttl = ttl;
        return r;
    endfunction

    function automatic t_res mk_report(
        input logic [7:0]  hop,
        input logic        valid,
        input logic [63:0] hi,
        input logic [63:0] lo,
        input logic [31:0] rtt,
        input logic [7:0]  resends,
        input logic [7:0]  trace_no,
        input logic        trace_end,
        input logic        all_done
    );
        t_res r;
        r                = '0;
        r.kind           = KIND_REPORT;
        r.hop            = hop;
        r.node_valid     = valid;
        r.node_addr_hi   = valid ? hi : 64'd0;
        r.node_addr_lo   = valid ? lo : 64'd0;
        r.report_rtt     = valid ? rtt : 32'd0;
        r.report_resends = valid ? resends : 8'd0;
        r.trace_number   = trace_no;
        r.trace_end      = trace_end;
        r.all_done       = all_done;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/sthc_out_queue.sv @@
// Two-entry result queue driving the master-side stream.
`default_nettype none

module sthc_out_queue (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  sthc_pkg::t_q_push                     i_push,
    input  sthc_pkg::t_res                        i_res0,
    input  sthc_pkg::t_res                        i_res1,
    output logic                                  o_empty,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // probe_ttl[7:0], hop[15:8], node_valid[16], node_addr_hi[80:17],
    // node_addr_lo[144:81], report_rtt[176:145], report_resends[184:177],
    // trace_number[192:185], trace_end[193], all_done[194], zero[199:195]
    output logic [sthc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind[0]
    output logic [sthc_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import sthc_pkg::*;

    t_res       r_slot [0:1];
    logic       r_head;
    logic [1:0] r_cnt;
    t_res       head_res;
    t_res       res0_l;
    t_res       res1_l;
    logic       pop;

    assign pop     = m_axis_tvalid && m_axis_tready;
    assign o_empty = (r_cnt == 2'd0);

    // occupancy and read pointer; a push only lands on an empty queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else if (i_push.push) begin
            r_cnt  <= i_push.nres;
            r_head <= 1'b0;
        end else if (pop) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= ~r_head;
        end
    end

    // last mark settled at push time
    always_comb begin
        res0_l      = i_res0;
        res0_l.last = (i_push.nres == 2'd1);
        res1_l      = i_res1;
        res1_l.last = 1'b1;
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[0] <= res0_l;
            r_slot[1] <= res1_l;
        end
    end

    // stream packing
    always_comb begin
        head_res      = r_slot[r_head];
        m_axis_tvalid = (r_cnt != 2'd0);
        m_axis_tuser  = head_res.kind;
        m_axis_tlast  = head_res.last;
        m_axis_tdata  = {5'd0,
                         head_res.all_done,
                         head_res.trace_end,
                         head_res.trace_number,
                         head_res.report_resends,
                         head_res.report_rtt,
                         head_res.node_addr_lo,
                         head_res.node_addr_hi,
                         head_res.node_valid,
                         head_res.hop,
                         head_res.probe_ttl};
    end

`include "stun_traceroute_hop_controller_unit_macros.svh"

    `STHC_ASSERT_IMP(a_push_on_empty, i_push.push, r_cnt == 2'd0)
    `STHC_ASSERT_IMP(a_push_count, i_push.push, i_push.nres == 2'd1 || i_push.nres == 2'd2)
    `STHC_ASSERT_NXT(a_pop_full, pop && r_cnt == 2'd2, r_cnt == 2'd1 && r_head)

endmodule

`default_nettype wire

@@ design/stun_traceroute_hop_controller_unit.sv @@
// Flow: an event is taken in S_IDLE and decoded in S_EXEC; start, bind and ICMP events
// pass from S_EXEC to S_EMIT and the result queue; an ICMP walk to the next hop adds S_WALK,
// which steps over each skipped inactive hop; a no-answer event adds a scan of the hop-flag
// memory, plus the walk. Events are taken one at a time: the slave stream stalls through the
// flag scan and walk, plus any wait for the result queue to empty before the push.
// Reset: synchronous, active low; a clearing pass over the hop-flag memory zeroes the flags.
`default_nettype none

module stun_traceroute_hop_controller_unit #(
    parameter int TOP_TTL    = 64,
    parameter int SILENT_RUN = 2
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // slave-side stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ttl[7:0], icmp_type[15:8], is_ipv6[16], src_is_remote[17],
    // src_addr_hi[81:18], src_addr_lo[145:82], round_trip[177:146],
    // resend_count[185:178], zero[191:186]
    input  wire  [sthc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type[1:0]
    input  wire  [sthc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // master-side stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // probe_ttl[7:0], hop[15:8], node_valid[16], node_addr_hi[80:17],
    // node_addr_lo[144:81], report_rtt[176:145], report_resends[184:177],
    // trace_number[192:185], trace_end[193], all_done[194], zero[199:195]
    output logic [sthc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // kind[0]
    output logic [sthc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                 m_axis_tlast,
    // configuration port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [sthc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [sthc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sthc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import sthc_pkg::*;

    localparam int         AW   = $clog2(TOP_TTL + 1);
    localparam int         RW   = $clog2(SILENT_RUN + 1);
    localparam logic [AW-1:0] TOPC = AW'(TOP_TTL);
    localparam logic [7:0] TOP8 = 8'(TOP_TTL);
    localparam logic [7:0] SR8  = 8'(SILENT_RUN);
    localparam logic [RW-1:0] SRR = RW'(SILENT_RUN);

    // configuration
    logic [7:0]    r_max_traces;
    logic [6:0]    r_hop_limit;

    // control state
    t_state        r_state, n_state;
    logic [7:0]    r_cur, n_cur;
    logic [7:0]    r_path, n_path;
    logic          r_alive, n_alive;
    logic [7:0]    r_trace, n_trace;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_run, n_run;
    logic          r_found, n_found;
    logic [1:0]    r_nres, n_nres;

    // payload
    t_in_item      r_in;
    t_res          r_res0, n_res0;
    t_res          r_res1, n_res1;

    // hop-flag memory
    logic          mem [0:TOP_TTL];
    logic          r_rd_data;
    logic          mem_we;
    logic [AW-1:0] wr_idx;
    logic          mem_wd;
    logic [AW-1:0] rd_src;
    logic          rd_ok;
    logic [AW-1:0] rd_idx;

    // decode helpers
    logic          in_xfer;
    logic          unreach, exceeded, ttl_top, cur_top, cur_in_range;
    logic          restart_ok, done_w, can_adv, path_ge_ttl;
    logic          walk_flag, walk_cont, scan_last, fin_found;
    logic          do_end, end_valid;
    logic [7:0]    end_hop;
    logic          q_empty;
    t_q_push       q_ctl;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign pready        = 1'b1;

    // configuration writes and reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_traces <= MAX_TRACES_RST;
            r_hop_limit  <= HOP_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MAX_TRACES: r_max_traces <= pwdata[7:0];
                REG_HOP_LIMIT:  r_hop_limit  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_TRACES: prdata = {24'd0, r_max_traces};
            REG_HOP_LIMIT:  prdata = {25'd0, r_hop_limit};
            default:        prdata = '0;
        endcase
    end

    // event decode
    assign unreach      = (r_in.icmp_type == ICMP4_UNREACH && !r_in.is_ipv6) ||
                          (r_in.icmp_type == ICMP6_UNREACH && r_in.is_ipv6);
    assign exceeded     = (r_in.icmp_type == ICMP4_EXCEEDED && !r_in.is_ipv6) ||
                          (r_in.icmp_type == ICMP6_EXCEEDED && r_in.is_ipv6);
    assign ttl_top      = (r_in.ttl == TOP8);
    assign cur_top      = (r_cur == TOP8);
    assign cur_in_range = (r_cur <= TOP8);
    assign restart_ok   = (r_trace < r_max_traces);
    assign done_w       = !restart_ok;
    assign can_adv      = ({1'b0, r_cur} + 9'd1) < {2'b00, r_hop_limit};
    assign path_ge_ttl  = (r_path >= r_in.ttl);

    // scan and walk status; read data belongs to the address issued last cycle
    assign scan_last = (r_cnt == TOPC);
    assign fin_found = r_found || (!r_rd_data && r_run == SRR);
    assign walk_flag = cur_in_range && r_rd_data;
    assign walk_cont = walk_flag && (r_cur < r_path);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (scan_last) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_EXEC;
            S_EXEC: begin
                unique case (r_in.req_type)
                    REQ_START: n_state = S_EMIT;
                    REQ_BIND: begin
                        if (ttl_top || (r_in.src_is_remote && path_ge_ttl)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_ICMP: begin
                        priority if (ttl_top && unreach) begin
                            n_state = S_EMIT;
                        end else if (exceeded) begin
                            n_state = can_adv ? S_WALK : S_EMIT;
                        end else if (unreach && path_ge_ttl) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_SILENT: n_state = cur_top ? S_EMIT : S_SCAN;
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (scan_last) begin
                    priority if (fin_found && !r_alive) begin
                        n_state = S_EMIT;
                    end else if (r_cur < {1'b0, r_hop_limit}) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_WALK:  if (!walk_cont) n_state = S_EMIT;
            S_EMIT:  if (q_empty) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cur     = r_cur;
        n_path    = r_path;
        n_alive   = r_alive;
        n_trace   = r_trace;
        n_cnt     = r_cnt;
        n_run     = r_run;
        n_found   = r_found;
        n_nres    = r_nres;
        n_res0    = r_res0;
        n_res1    = r_res1;
        mem_we    = 1'b0;
        wr_idx    = r_cnt;
        mem_wd    = 1'b0;
        do_end    = 1'b0;
        end_valid = 1'b0;
        end_hop   = r_in.ttl;
        q_ctl     = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = scan_last ? '0 : r_cnt + AW'(1);
            end
            S_IDLE: n_nres = 2'd0;
            S_EXEC: begin
                unique case (r_in.req_type)
                    REQ_START: begin
                        n_cur   = TOP8;
                        n_path  = PATH_OPEN;
                        n_trace = 8'd1;
                        n_res0  = mk_probe(TOP8);
                        n_nres  = 2'd1;
                    end
                    REQ_BIND: begin
                        if (ttl_top) begin
                            n_alive = 1'b1;
                            n_cur   = 8'd1;
                            n_res0  = mk_probe(8'd1);
                            n_nres  = 2'd1;
                        end else if (r_in.src_is_remote && path_ge_ttl) begin
                            n_path    = r_in.ttl;
                            do_end    = 1'b1;
                            end_valid = 1'b1;
                        end
                    end
                    REQ_ICMP: begin
                        priority if (ttl_top && unreach) begin
                            n_alive = 1'b1;
                            n_cur   = 8'd1;
                            n_res0  = mk_probe(8'd1);
                            n_nres  = 2'd1;
                        end else if (exceeded) begin
                            if (can_adv) begin
                                n_cur = r_cur + 8'd1;
                            end else begin
                                do_end    = 1'b1;
                                end_valid = 1'b1;
                            end
                        end else if (unreach && path_ge_ttl) begin
                            n_path    = r_in.ttl;
                            do_end    = 1'b1;
                            end_valid = 1'b1;
                        end
                    end
                    REQ_SILENT: begin
                        // mark the unanswered hop, then test the alive probe
                        mem_we = cur_in_range;
                        wr_idx = r_cur[AW-1:0];
                        mem_wd = 1'b1;
                        if (cur_top) begin
                            n_alive = 1'b0;
                            n_cur   = 8'd1;
                            n_res0  = mk_probe(8'd1);
                            n_nres  = 2'd1;
                        end else begin
                            n_cnt   = '0;
                            n_run   = '0;
                            n_found = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                // run length saturates at the silent-run threshold
                if (!scan_last) n_cnt = r_cnt + AW'(1);
                if (r_cnt != '0) begin
                    if (r_rd_data) begin
                        n_run = (r_run == SRR) ? r_run : r_run + RW'(1);
                    end else begin
                        n_found = fin_found;
                        n_run   = '0;
                    end
                end
                if (scan_last) begin
                    if (fin_found && !r_alive) begin
                        n_path  = (r_cur >= SR8) ? r_cur - SR8 : 8'd0;
                        do_end  = 1'b1;
                        end_hop = r_cur;
                    end else begin
                        n_res0 = mk_report(r_cur, 1'b0, 64'd0, 64'd0, 32'd0, 8'd0,
                                           r_trace, 1'b0, 1'b0);
                        n_nres = 2'd1;
                    end
                end
            end
            S_WALK: begin
                if (walk_cont) begin
                    n_cur = r_cur + 8'd1;
                end else if (r_in.req_type == REQ_SILENT) begin
                    n_res1 = mk_probe(r_cur);
                    n_nres = 2'd2;
                end else if (r_cur <= r_path) begin
                    n_res0 = mk_report(r_in.ttl, 1'b1, r_in.src_addr_hi, r_in.src_addr_lo,
                                       r_in.round_trip, r_in.resend_count, r_trace,
                                       1'b0, 1'b0);
                    n_res1 = mk_probe(r_cur);
                    n_nres = 2'd2;
                end else begin
                    do_end    = 1'b1;
                    end_valid = 1'b1;
                end
            end
            S_EMIT: begin
                q_ctl.push = q_empty;
                q_ctl.nres = r_nres;
            end
            default: ;
        endcase

        // trace-ending report, then a restart probe while traces remain
        if (do_end) begin
            n_res0 = mk_report(end_hop, end_valid, r_in.src_addr_hi, r_in.src_addr_lo,
                               r_in.round_trip, r_in.resend_count, r_trace, 1'b1, done_w);
            if (restart_ok) begin
                n_trace = r_trace + 8'd1;
                n_cur   = 8'd1;
                n_res1  = mk_probe(8'd1);
                n_nres  = 2'd2;
            end else begin
                n_nres  = 2'd1;
            end
        end
    end

    // read address: scan counter, else the hop the walk looks at next
    always_comb begin
        if (r_state == S_SCAN && !scan_last) begin
            rd_src = r_cnt;
            rd_ok  = 1'b1;
        end else begin
            rd_src = n_cur[AW-1:0];
            rd_ok  = (n_cur <= TOP8);
        end
        rd_idx = rd_ok ? rd_src : '0;
    end

    // hop-flag memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_idx] <= mem_wd;
        r_rd_data <= mem[rd_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur   <= 8'd0;
            r_path  <= PATH_OPEN;
            r_alive <= 1'b0;
            r_trace <= 8'd1;
            r_cnt   <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
            r_nres  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_path  <= n_path;
            r_alive <= n_alive;
            r_trace <= n_trace;
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_found <= n_found;
            r_nres  <= n_nres;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.req_type      <= t_req'(s_axis_tuser[1:0]);
            r_in.ttl           <= s_axis_tdata[7:0];
            r_in.icmp_type     <= s_axis_tdata[15:8];
            r_in.is_ipv6       <= s_axis_tdata[16];
            r_in.src_is_remote <= s_axis_tdata[17];
            r_in.src_addr_hi   <= s_axis_tdata[81:18];
            r_in.src_addr_lo   <= s_axis_tdata[145:82];
            r_in.round_trip    <= s_axis_tdata[177:146];
            r_in.resend_count  <= s_axis_tdata[185:178];
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    sthc_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_ctl),
        .i_res0        (r_res0),
        .i_res1        (r_res1),
        .o_empty       (q_empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`include "stun_traceroute_hop_controller_unit_macros.svh"

    `STHC_ASSERT_IMP(a_mem_we_phase, mem_we, r_state == S_CLEAR || r_state == S_EXEC)
    `STHC_ASSERT_IMP(a_scan_bound, r_state == S_SCAN, r_cnt <= TOPC)
    `STHC_ASSERT_IMP(a_trace_nonzero, r_state != S_CLEAR, r_trace != 8'd0)
    `STHC_ASSERT_IMP(a_push_has_results, q_ctl.push, r_nres != 2'd0)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the traceroute hop controller: stream events in, predicted results out.
`timescale 1ns / 100ps

module tb_top;
    import sthc_pkg::*;

    localparam int TOP_TTL      = 64;
    localparam int SILENT_RUN   = 2;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 2000000;

    // DUT connections; everything driven from the testbench starts at a known value
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Traffic shaping
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_left   = 0;
    int errors      = 0;
    int cycle_count = 0;

    // Shadow of the controller state and its registers
    logic [7:0] cfg_max_traces;
    logic [6:0] cfg_hop_limit;
    logic [7:0] probe_ttl_now;
    logic [7:0] path_limit_now;
    logic       hop_silent [0:TOP_TTL];
    logic       far_end_alive;
    logic [7:0] trace_no;

    t_res step_out[$];
    t_res hop_results_due[$];

    stun_traceroute_hop_controller_unit #(
        .TOP_TTL    (TOP_TTL),
        .SILENT_RUN (SILENT_RUN)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ---------------- prediction ----------------

    function automatic logic flag_at(input logic [7:0] idx);
        return (idx <= TOP_TTL) ? hop_silent[idx] : 1'b0;
    endfunction

    // Longest run of silent hops below TOP_TTL that an answering hop closes
    function automatic int longest_silent_run();
        int best;
        int run;
        best = 0;
        run  = 0;
        for (int i = 0; i < TOP_TTL; i++) begin
            if (hop_silent[i]) begin
                run++;
            end else begin
                if (run > best) best = run;
                run = 0;
            end
        end
        return best;
    endfunction

    function automatic t_res probe_req(input logic [7:0] ttl);
        t_res r;
        r           = '0;
        r.kind      = KIND_PROBE;
        r.probe_ttl = ttl;
        return r;
    endfunction

    function automatic t_res hop_report(input t_in_item it, input logic [7:0] hop,
                                        input logic answered, input logic ends,
                                        input logic done);
        t_res r;
        r              = '0;
        r.kind         = KIND_REPORT;
        r.hop          = hop;
        r.node_valid   = answered;
        r.trace_number = trace_no;
        r.trace_end    = ends;
        r.all_done     = done;
        if (answered) begin
            r.node_addr_hi   = it.src_addr_hi;
            r.node_addr_lo   = it.src_addr_lo;
            r.report_rtt     = it.round_trip;
            r.report_resends = it.resend_count;
        end
        return r;
    endfunction

    task automatic skip_silent_hops();
        while (flag_at(probe_ttl_now) && probe_ttl_now < path_limit_now)
            probe_ttl_now++;
    endtask

    task automatic next_trace();
        if (trace_no < cfg_max_traces) begin
            trace_no++;
            probe_ttl_now = 8'd1;
            step_out.push_back(probe_req(8'd1));
        end
    endtask

    task automatic predict_hop_event(input t_in_item it);
        logic done;
        logic unreach;
        logic exceeded;
        logic walked;
        done     = !(trace_no < cfg_max_traces);
        unreach  = (it.icmp_type == ICMP4_UNREACH && !it.is_ipv6) ||
                   (it.icmp_type == ICMP6_UNREACH && it.is_ipv6);
        exceeded = (it.icmp_type == ICMP4_EXCEEDED && !it.is_ipv6) ||
                   (it.icmp_type == ICMP6_EXCEEDED && it.is_ipv6);
        walked   = 1'b0;
        step_out.delete();
        case (it.req_type)
            REQ_START: begin
                probe_ttl_now  = 8'(TOP_TTL);
                path_limit_now = PATH_OPEN;
                trace_no       = 8'd1;
                step_out.push_back(probe_req(8'(TOP_TTL)));
            end
            REQ_BIND: begin
                if (it.ttl == TOP_TTL) begin
                    far_end_alive = 1'b1;
                    probe_ttl_now = 8'd1;
                    step_out.push_back(probe_req(8'd1));
                end else if (it.src_is_remote && path_limit_now >= it.ttl) begin
                    path_limit_now = it.ttl;
                    step_out.push_back(hop_report(it, it.ttl, 1'b1, 1'b1, done));
                    next_trace();
                end
            end
            REQ_ICMP: begin
                if (it.ttl == TOP_TTL && unreach) begin
                    far_end_alive = 1'b1;
                    probe_ttl_now = 8'd1;
                    step_out.push_back(probe_req(8'd1));
                end else if (exceeded) begin
                    // signed compare: a hop limit of one never lets the walk advance
                    if (int'(probe_ttl_now) < int'(cfg_hop_limit) - 1) begin
                        probe_ttl_now++;
                        skip_silent_hops();
                        if (probe_ttl_now <= path_limit_now) begin
                            step_out.push_back(hop_report(it, it.ttl, 1'b1, 1'b0, 1'b0));
                            step_out.push_back(probe_req(probe_ttl_now));
                            walked = 1'b1;
                        end
                    end
                    if (!walked) begin
                        step_out.push_back(hop_report(it, it.ttl, 1'b1, 1'b1, done));
                        next_trace();
                    end
                end else if (unreach) begin
                    if (path_limit_now >= it.ttl) begin
                        path_limit_now = it.ttl;
                        step_out.push_back(hop_report(it, it.ttl, 1'b1, 1'b1, done));
                        next_trace();
                    end
                end
            end
            REQ_SILENT: begin
                if (probe_ttl_now <= TOP_TTL) hop_silent[probe_ttl_now] = 1'b1;
                if (probe_ttl_now == TOP_TTL) begin
                    far_end_alive = 1'b0;
                    probe_ttl_now = 8'd1;
                    step_out.push_back(probe_req(8'd1));
                end else if (longest_silent_run() >= SILENT_RUN && !far_end_alive) begin
                    // path limit saturates at zero below the silent run
                    path_limit_now = (probe_ttl_now >= SILENT_RUN) ?
                                     probe_ttl_now - 8'(SILENT_RUN) : 8'd0;
                    step_out.push_back(hop_report(it, probe_ttl_now, 1'b0, 1'b1, done));
                    next_trace();
                end else begin
                    step_out.push_back(hop_report(it, probe_ttl_now, 1'b0, 1'b0, 1'b0));
                    if (probe_ttl_now < cfg_hop_limit) begin
                        skip_silent_hops();
                        step_out.push_back(probe_req(probe_ttl_now));
                    end
                end
            end
        endcase
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) hop_results_due.push_back(step_out[i]);
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind           = m_axis_tuser[0];
            got.probe_ttl      = m_axis_tdata[7:0];
            got.hop            = m_axis_tdata[15:8];
            got.node_valid     = m_axis_tdata[16];
            got.node_addr_hi   = m_axis_tdata[80:17];
            got.node_addr_lo   = m_axis_tdata[144:81];
            got.report_rtt     = m_axis_tdata[176:145];
            got.report_resends = m_axis_tdata[184:177];
            got.trace_number   = m_axis_tdata[192:185];
            got.trace_end      = m_axis_tdata[193];
            got.all_done       = m_axis_tdata[194];
            got.last           = m_axis_tlast;
            if (hop_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
            end else begin
                want = hop_results_due.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("probe_ttl", want.probe_ttl, got.probe_ttl);
                check_field("hop", want.hop, got.hop);
                check_field("node_valid", want.node_valid, got.node_valid);
                check_field("node_addr_hi", want.node_addr_hi, got.node_addr_hi);
                check_field("node_addr_lo", want.node_addr_lo, got.node_addr_lo);
                check_field("report_rtt", want.report_rtt, got.report_rtt);
                check_field("report_resends", want.report_resends, got.report_resends);
                check_field("trace_number", want.trace_number, got.trace_number);
                check_field("trace_end", want.trace_end, got.trace_end);
                check_field("all_done", want.all_done, got.all_done);
                check_field("last", want.last, got.last);
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // One event transfer, with random sender gaps ahead of it
    task automatic send_event(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {6'd0, it.resend_count, it.round_trip, it.src_addr_lo,
                         it.src_addr_hi, it.src_is_remote, it.is_ipv6, it.icmp_type, it.ttl};
        s_axis_tuser  = it.req_type;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_hop_event(it);
    endtask

    // Stop offering, let all results drain, then cover events that gave no result
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (hop_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_MAX_TRACES) cfg_max_traces = data[7:0];
        else cfg_hop_limit = data[6:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input int max_traces, input int hop_limit);
        wait_drained();
        apb_write(REG_MAX_TRACES, 32'(max_traces));
        apb_write(REG_HOP_LIMIT, 32'(hop_limit));
    endtask

    function automatic t_in_item make_event(input t_req req, input logic [7:0] ttl,
                                            input logic [7:0] ity, input logic v6,
                                            input logic remote);
        t_in_item it;
        it.req_type      = req;
        it.ttl           = ttl;
        it.icmp_type     = ity;
        it.is_ipv6       = v6;
        it.src_is_remote = remote;
        it.src_addr_hi   = {$urandom, $urandom};
        it.src_addr_lo   = {$urandom, $urandom};
        it.round_trip    = $urandom;
        it.resend_count  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Mostly answers to the probe in flight, with some noise
    function automatic t_in_item rand_event();
        t_in_item it;
        int pick;
        t_req req;
        logic [7:0] ttl;
        logic [7:0] ity;
        logic v6;
        v6   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 4)       req = REQ_START;
        else if (pick < 16) req = REQ_BIND;
        else if (pick < 74) req = REQ_ICMP;
        else                req = REQ_SILENT;
        pick = $urandom_range(0, 99);
        if (pick < 60)      ttl = probe_ttl_now;
        else if (pick < 75) ttl = 8'(TOP_TTL);
        else                ttl = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 50)      ity = v6 ? ICMP6_EXCEEDED : ICMP4_EXCEEDED;
        else if (pick < 75) ity = v6 ? ICMP6_UNREACH : ICMP4_UNREACH;
        else                ity = 8'($urandom_range(0, 255));
        it = make_event(req, ttl, ity, v6, 1'($urandom_range(0, 1)));
        return it;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        t_in_item it;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(1, 40);
        // no answer straight after reset marks hop zero
        send_event(make_event(REQ_SILENT, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
        // far end silent at the top TTL
        send_event(make_event(REQ_SILENT, 8'd64, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd1, ICMP4_EXCEEDED, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd2, ICMP6_EXCEEDED, 1'b1, 1'b0));
        // two silent hops in a row end the trace
        send_event(make_event(REQ_SILENT, 8'd3, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_SILENT, 8'd4, 8'd0, 1'b0, 1'b0));
        // silent run at TTL one: path limit saturates at zero
        send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_SILENT, 8'd64, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_SILENT, 8'd1, 8'd0, 1'b0, 1'b0));

        // restarts across several traces
        set_config(3, 40);
        send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd64, ICMP4_UNREACH, 1'b0, 1'b0));
        send_event(make_event(REQ_BIND, 8'd64, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_BIND, 8'd30, 8'd0, 1'b0, 1'b1));
        send_event(make_event(REQ_BIND, 8'd5, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd40, ICMP6_UNREACH, 1'b1, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd30, ICMP4_UNREACH, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd10, ICMP6_UNREACH, 1'b1, 1'b0));
        // unlisted ICMP types are dropped
        send_event(make_event(REQ_ICMP, 8'd10, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_ICMP, 8'd10, 8'd255, 1'b1, 1'b1));

        // hop limit of one blocks the walk
        set_config(255, 1);
        send_event(make_event(REQ_ICMP, 8'd1, ICMP4_EXCEEDED, 1'b0, 1'b0));
        send_event(make_event(REQ_SILENT, 8'd1, 8'd0, 1'b0, 1'b0));
        // field extremes
        it = '0;
        send_event(it);
        it = '1;
        send_event(it);
    endtask

    task automatic test_random(input int phase, input int tx_pct, input int rx_pct,
                               input int count);
        for (int blk = 0; blk < 3; blk++) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            if (blk == 0)
                set_config((phase == 1) ? 1 : 255, (phase == 1) ? 1 : 64);
            else if (phase == 2 && blk == 2)
                set_config($urandom_range(1, 255), $urandom_range(1, 64));
            else
                set_config($urandom_range(1, 5), $urandom_range(1, 64));
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
            repeat (count / 3) send_event(rand_event());
        end
    endtask

    // Receiver holds off while events keep coming, so the block backs up
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(3, 64);
        hold_req = 1;
        send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
        repeat (40) send_event(rand_event());
    endtask

    // With the far end alive, no-answer events mark every hop up to TOP_TTL
    task automatic test_flag_walk();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(255, 64);
        send_event(make_event(REQ_START, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_BIND, 8'd64, 8'd0, 1'b0, 1'b0));
        repeat (70) send_event(make_event(REQ_SILENT, probe_ttl_now, 8'd0, 1'b0, 1'b0));
        repeat (3) send_event(make_event(REQ_ICMP, probe_ttl_now, ICMP4_EXCEEDED, 1'b0, 1'b0));
    endtask

    initial begin
        cfg_max_traces = MAX_TRACES_RST;
        cfg_hop_limit  = HOP_LIMIT_RST;
        probe_ttl_now  = 8'd0;
        path_limit_now = PATH_OPEN;
        far_end_alive  = 1'b0;
        trace_no       = 8'd1;
        foreach (hop_silent[i]) hop_silent[i] = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(0, 11, 83, 400);
        test_random(1, 83, 11, 400);
        test_random(2, 0, 0, 400);
        test_backpressure();
        test_flag_walk();

        wait_drained();
        if (errors == 0 && hop_results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
